### src/spdl_pkg.sv
// spdl_pkg: shared types, constants and arithmetic step functions for the
// spectrum peak decay log scaler. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spdl_pkg;

  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned SQ_STEPS  = 17;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned LOG_STEPS = 16;
  localparam int unsigned MOD_STEPS = 10;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_DECAY = 3'd1;
  localparam logic [2:0] REG_PHASE = 3'd2;
  localparam logic [2:0] REG_FLOOR = 3'd3;
  localparam logic [2:0] REG_SCALE = 3'd4;

  localparam logic [1:0] MODE_MONO  = 2'd0;
  localparam logic [1:0] MODE_SEP   = 2'd1;
  localparam logic [1:0] MODE_PHASE = 2'd2;

  localparam logic [1:0]  RST_MODE  = MODE_MONO;
  localparam logic [15:0] RST_DECAY = 16'd62259;
  localparam logic [15:0] RST_PHASE = 16'd65200;
  localparam logic [15:0] RST_FLOOR = 16'hEC12;
  localparam logic [15:0] RST_SCALE = 16'd3288;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [9:0]         bin_index;
    logic signed [15:0] left_real;
    logic signed [15:0] left_imag;
    logic signed [15:0] right_real;
    logic signed [15:0] right_imag;
  } in_t;

  typedef struct packed {
    logic [9:0]  out_bin;
    logic [15:0] left_level;
    logic [15:0] right_level;
    logic [15:0] phase_level;
  } out_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] decay_pole;
    logic [15:0] phase_pole;
    logic [15:0] log_floor;
    logic [15:0] log_scale;
  } cfg_t;

  typedef struct packed {
    logic [33:0] v;
    logic [34:0] r;
  } sq_t;

  typedef struct packed {
    logic [9:0] bin;
    logic [9:0] bmod;
    sq_t        l;
    sq_t        r;
    sq_t        s;
  } fsq_t;

  typedef struct packed {
    logic [9:0]  bin;
    logic [9:0]  bmod;
    logic [16:0] lmag;
    logic [16:0] rmag;
    logic [17:0] sum;
    logic [17:0] rem;
    logic [15:0] q;
    logic        zero;
    logic        sat;
  } fdv_t;

  typedef struct packed {
    logic [9:0]  bin;
    logic [9:0]  bmod;
    logic [16:0] lmag;
    logic [16:0] rmag;
    logic [16:0] x;
  } fq_t;

  typedef struct packed {
    logic        zero;
    logic [4:0]  e;
    logic [30:0] m;
    logic [15:0] frac;
  } lg_t;

  typedef struct packed {
    logic [9:0]  bin;
    logic        rsel;
    logic        psel;
    logic [15:0] pval;
  } bk_t;

  // one digit of the integer square root
  function automatic sq_t sq_step(sq_t a, int unsigned k);
    logic [34:0] bitv;
    logic [34:0] t;
    sq_t         o;
    bitv = 35'(1) << (32 - 2 * k);
    t    = a.r + bitv;
    if ({1'b0, a.v} >= t) begin
      o.v = 34'({1'b0, a.v} - t);
      o.r = (a.r >> 1) + bitv;
    end else begin
      o.v = a.v;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  // one quotient bit of the restoring division
  function automatic fdv_t dv_step(fdv_t a);
    logic [18:0] rem2;
    fdv_t        o;
    o    = a;
    rem2 = {a.rem, 1'b0};
    if (rem2 >= {1'b0, a.sum}) begin
      o.rem = 18'(rem2 - {1'b0, a.sum});
      o.q   = {a.q[14:0], 1'b1};
    end else begin
      o.rem = rem2[17:0];
      o.q   = {a.q[14:0], 1'b0};
    end
    return o;
  endfunction

  function automatic lg_t lg_norm(logic [16:0] p);
    lg_t o;
    o.zero = (p == 17'd0);
    o.e    = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (p[i]) begin
        o.e = 5'(i);
      end
    end
    o.m    = 31'({14'd0, p} << (5'd30 - o.e));
    o.frac = 16'd0;
    return o;
  endfunction

  // square the mantissa and take one fraction bit
  function automatic lg_t lg_step(lg_t a);
    logic [61:0] sq;
    logic [31:0] t;
    lg_t         o;
    o      = a;
    sq     = a.m * a.m;
    t      = sq[61:30];
    o.frac = {a.frac[14:0], t[31]};
    o.m    = t[31] ? t[31:1] : t[30:0];
    return o;
  endfunction

  // log distance above the floor, zero when at or below it
  function automatic logic [23:0] lg_dist(lg_t a, logic [15:0] floor);
    logic [5:0]  es;
    logic [25:0] l;
    logic [25:0] f;
    logic [25:0] d;
    es = {1'b0, a.e} - 6'd15;
    l  = {{4{es[5]}}, es, a.frac};
    f  = {{2{floor[15]}}, floor, 8'd0};
    d  = l - f;
    if (a.zero || d[25] || (d == 26'd0)) begin
      return 24'd0;
    end
    return d[23:0];
  endfunction

  function automatic logic [16:0] pk_hold(logic [16:0] pk, logic [16:0] mag,
                                          logic [15:0] pole);
    logic [32:0] pr;
    pr = pk * pole;
    return (mag > pr[32:16]) ? mag : pr[32:16];
  endfunction

  function automatic logic [16:0] ph_smooth(logic [16:0] s, logic [16:0] x,
                                            logic [15:0] pole);
    logic [33:0] a;
    logic [33:0] b;
    logic [33:0] t;
    a = s * pole;
    b = x * (ONE_Q16 - {1'b0, pole});
    t = a + b;
    return t[32:16];
  endfunction

endpackage

`default_nettype wire

### src/spdl_fifo.sv
// spdl_fifo: short queue between the magnitude front end and the store back end.
// Depends on spdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spdl_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  spdl_pkg::fq_t   push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output spdl_pkg::fq_t   pop_data_o,
  output logic            empty_o
);

  localparam int unsigned PW = $clog2(spdl_pkg::QDEPTH);

  spdl_pkg::fq_t  mem_q [spdl_pkg::QDEPTH];
  logic [PW-1:0]  wptr_q;
  logic [PW-1:0]  rptr_q;
  logic [PW:0]    cnt_q;

  assign full_o     = (cnt_q == (PW + 1)'(spdl_pkg::QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### src/spdl_front.sv
// spdl_front: accepts bins, reduces the bin index, computes magnitudes by a
// pipelined square root and the phase ratio by a pipelined divider. Uses spdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spdl_front #(
  parameter int unsigned BINS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spdl_pkg::in_t in_data_i,
  input  logic          busy_i,
  input  logic          full_i,
  output logic          push_o,
  output spdl_pkg::fq_t push_data_o
);

  localparam int unsigned NSQ = spdl_pkg::SQ_STEPS;
  localparam int unsigned NDV = spdl_pkg::DIV_STEPS;
  localparam int unsigned NST = NSQ + NDV + 3;

  logic [NST-1:0]  fv_q;
  logic            fe;
  spdl_pkg::in_t   in_q;
  spdl_pkg::fsq_t  sqp_q [NSQ+1];
  spdl_pkg::fdv_t  dv_q  [NDV+1];
  spdl_pkg::fsq_t  sq0_d;
  spdl_pkg::fdv_t  dv0_d;

  logic signed [31:0] p_lr, p_li, p_rr, p_ri;
  logic signed [16:0] s_re, s_im;
  logic signed [33:0] p_sr, p_si;

  assign fe         = !fv_q[NST-1] || !full_i;
  assign in_ready_o = fe && !busy_i;
  assign push_o     = fv_q[NST-1] && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (fe) begin
      fv_q <= {fv_q[NST-2:0], in_valid_i && in_ready_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      in_q <= in_data_i;
    end
  end

  // squares
  always_comb begin
    p_lr = in_q.left_real * in_q.left_real;
    p_li = in_q.left_imag * in_q.left_imag;
    p_rr = in_q.right_real * in_q.right_real;
    p_ri = in_q.right_imag * in_q.right_imag;
    s_re = {in_q.left_real[15], in_q.left_real} + {in_q.right_real[15], in_q.right_real};
    s_im = {in_q.left_imag[15], in_q.left_imag} + {in_q.right_imag[15], in_q.right_imag};
    p_sr = s_re * s_re;
    p_si = s_im * s_im;
    sq0_d.bin  = in_q.bin_index;
    sq0_d.bmod = in_q.bin_index;
    sq0_d.l.v  = 34'(p_lr) + 34'(p_li);
    sq0_d.l.r  = '0;
    sq0_d.r.v  = 34'(p_rr) + 34'(p_ri);
    sq0_d.r.r  = '0;
    sq0_d.s.v  = p_sr[33:0] + p_si[33:0];
    sq0_d.s.r  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      sqp_q[0] <= sq0_d;
    end
  end

  // square root digits, bin reduction in the first steps
  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    localparam bit          DO_MOD = (k < spdl_pkg::MOD_STEPS);
    localparam int unsigned SH     = DO_MOD ? (spdl_pkg::MOD_STEPS - 1 - k) : 0;
    localparam int unsigned MSUB   = BINS << SH;
    spdl_pkg::fsq_t sq_d;

    always_comb begin
      sq_d   = sqp_q[k];
      sq_d.l = spdl_pkg::sq_step(sqp_q[k].l, k);
      sq_d.r = spdl_pkg::sq_step(sqp_q[k].r, k);
      sq_d.s = spdl_pkg::sq_step(sqp_q[k].s, k);
      if (DO_MOD && ({22'd0, sqp_q[k].bmod} >= MSUB)) begin
        sq_d.bmod = sqp_q[k].bmod - 10'(MSUB);
      end
    end

    always_ff @(posedge clk_i) begin
      if (fe) begin
        sqp_q[k+1] <= sq_d;
      end
    end
  end

  always_comb begin
    dv0_d.bin  = sqp_q[NSQ].bin;
    dv0_d.bmod = sqp_q[NSQ].bmod;
    dv0_d.lmag = sqp_q[NSQ].l.r[16:0];
    dv0_d.rmag = sqp_q[NSQ].r.r[16:0];
    dv0_d.sum  = {1'b0, sqp_q[NSQ].l.r[16:0]} + {1'b0, sqp_q[NSQ].r.r[16:0]};
    dv0_d.rem  = {1'b0, sqp_q[NSQ].s.r[16:0]};
    dv0_d.q    = '0;
    dv0_d.zero = (dv0_d.sum == 18'd0);
    dv0_d.sat  = ({1'b0, sqp_q[NSQ].s.r[16:0]} >= dv0_d.sum);
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      dv_q[0] <= dv0_d;
    end
  end

  for (genvar j = 0; j < NDV; j++) begin : g_dv
    always_ff @(posedge clk_i) begin
      if (fe) begin
        dv_q[j+1] <= spdl_pkg::dv_step(dv_q[j]);
      end
    end
  end

  always_comb begin
    push_data_o.bin  = dv_q[NDV].bin;
    push_data_o.bmod = dv_q[NDV].bmod;
    push_data_o.lmag = dv_q[NDV].lmag;
    push_data_o.rmag = dv_q[NDV].rmag;
    if (dv_q[NDV].zero) begin
      push_data_o.x = spdl_pkg::ONE_Q16;
    end else if (dv_q[NDV].sat) begin
      push_data_o.x = 17'd0;
    end else begin
      push_data_o.x = spdl_pkg::ONE_Q16 - {1'b0, dv_q[NDV].q};
    end
  end

endmodule

`default_nettype wire

### src/spdl_back.sv
// spdl_back: per-bin peak and phase store with read-modify-write, clearing pass
// after reset, pipelined log2 and level scaling, output register. Uses spdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spdl_back #(
  parameter int unsigned BINS = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spdl_pkg::cfg_t cfg_i,
  input  logic           empty_i,
  output logic           pop_o,
  input  spdl_pkg::fq_t  pop_data_i,
  output logic           busy_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spdl_pkg::out_t out_data_o
);

  localparam int unsigned AW  = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int unsigned NLG = spdl_pkg::LOG_STEPS;
  localparam int unsigned NP  = NLG + 3;

  logic [16:0] lmem [BINS];
  logic [16:0] rmem [BINS];
  logic [16:0] smem [BINS];

  logic           be;
  logic           busy_q;
  logic [AW-1:0]  clr_cnt_q;

  logic           b1_v_q;
  spdl_pkg::fq_t  b1_q;
  logic [16:0]    rdl_q, rdr_q, rds_q;
  logic [AW-1:0]  b1_addr;
  logic           fwd;
  logic [16:0]    lold, rold, sold, lin, lnew, rnew, snew;

  logic           b2_v_q;
  logic [AW-1:0]  b2_addr_q;
  logic [16:0]    b2_lpk_q, b2_rpk_q, b2_sm_q;
  logic [9:0]     b2_bin_q;
  logic [1:0]     b2_mode_q;

  logic           we;
  logic [AW-1:0]  wa;
  logic [16:0]    wd_l, wd_r, wd_s;

  logic [NP-1:0]  pv_q;
  spdl_pkg::lg_t  lgl_q [NLG+1];
  spdl_pkg::lg_t  lgr_q [NLG+1];
  spdl_pkg::bk_t  side_q [NP];
  spdl_pkg::bk_t  side0_d;
  logic [23:0]    dl_q, dr_q;
  logic [39:0]    pl_q, pr_q;

  logic           out_valid_q;
  spdl_pkg::out_t out_data_q;
  spdl_pkg::out_t out_data_d;

  assign be          = !out_valid_q || out_ready_i;
  assign pop_o       = be && !empty_i && !busy_q;
  assign busy_o      = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(BINS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // store read
  always_ff @(posedge clk_i) begin
    if (be) begin
      rdl_q <= lmem[AW'(pop_data_i.bmod)];
      rdr_q <= rmem[AW'(pop_data_i.bmod)];
      rds_q <= smem[AW'(pop_data_i.bmod)];
      b1_q  <= pop_data_i;
    end
  end

  // update with bypass from the item written one transfer ago
  always_comb begin
    b1_addr = AW'(b1_q.bmod);
    fwd     = b2_v_q && (b2_addr_q == b1_addr);
    lold    = fwd ? b2_lpk_q : rdl_q;
    rold    = fwd ? b2_rpk_q : rdr_q;
    sold    = fwd ? b2_sm_q  : rds_q;
    if (cfg_i.mode == spdl_pkg::MODE_PHASE) begin
      lin = 17'(({1'b0, b1_q.lmag} + {1'b0, b1_q.rmag}) >> 1);
    end else begin
      lin = b1_q.lmag;
    end
    lnew = spdl_pkg::pk_hold(lold, lin, cfg_i.decay_pole);
    rnew = (cfg_i.mode == spdl_pkg::MODE_SEP) ?
           spdl_pkg::pk_hold(rold, b1_q.rmag, cfg_i.decay_pole) : rold;
    snew = (cfg_i.mode == spdl_pkg::MODE_PHASE) ?
           spdl_pkg::ph_smooth(sold, b1_q.x, cfg_i.phase_pole) : sold;
  end

  // store write
  always_comb begin
    we   = busy_q || (be && b1_v_q);
    wa   = busy_q ? clr_cnt_q : b1_addr;
    wd_l = busy_q ? 17'd0 : lnew;
    wd_r = busy_q ? 17'd0 : rnew;
    wd_s = busy_q ? 17'd0 : snew;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      lmem[wa] <= wd_l;
      rmem[wa] <= wd_r;
      smem[wa] <= wd_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q      <= 1'b0;
      b2_v_q      <= 1'b0;
      pv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (be) begin
      b1_v_q      <= pop_o;
      b2_v_q      <= b1_v_q;
      pv_q        <= {pv_q[NP-2:0], b2_v_q};
      out_valid_q <= pv_q[NP-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      b2_addr_q <= b1_addr;
      b2_lpk_q  <= lnew;
      b2_rpk_q  <= rnew;
      b2_sm_q   <= snew;
      b2_bin_q  <= b1_q.bin;
      b2_mode_q <= cfg_i.mode;
    end
  end

  // log2 pipeline
  always_comb begin
    side0_d.bin  = b2_bin_q;
    side0_d.rsel = (b2_mode_q == spdl_pkg::MODE_SEP);
    side0_d.psel = (b2_mode_q == spdl_pkg::MODE_PHASE);
    side0_d.pval = b2_sm_q[16] ? 16'hFFFF : b2_sm_q[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      lgl_q[0]  <= spdl_pkg::lg_norm(b2_lpk_q);
      lgr_q[0]  <= spdl_pkg::lg_norm(b2_rpk_q);
      side_q[0] <= side0_d;
    end
  end

  for (genvar i = 0; i < NLG; i++) begin : g_lg
    always_ff @(posedge clk_i) begin
      if (be) begin
        lgl_q[i+1]  <= spdl_pkg::lg_step(lgl_q[i]);
        lgr_q[i+1]  <= spdl_pkg::lg_step(lgr_q[i]);
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      dl_q         <= spdl_pkg::lg_dist(lgl_q[NLG], cfg_i.log_floor);
      dr_q         <= spdl_pkg::lg_dist(lgr_q[NLG], cfg_i.log_floor);
      side_q[NLG+1] <= side_q[NLG];
      pl_q         <= dl_q * cfg_i.log_scale;
      pr_q         <= dr_q * cfg_i.log_scale;
      side_q[NLG+2] <= side_q[NLG+1];
      out_data_q   <= out_data_d;
    end
  end

  always_comb begin
    out_data_d.out_bin     = side_q[NP-1].bin;
    out_data_d.left_level  = (pl_q[39:32] != 8'd0) ? 16'hFFFF : pl_q[31:16];
    if (side_q[NP-1].rsel) begin
      out_data_d.right_level = (pr_q[39:32] != 8'd0) ? 16'hFFFF : pr_q[31:16];
    end else begin
      out_data_d.right_level = 16'd0;
    end
    out_data_d.phase_level = side_q[NP-1].psel ? side_q[NP-1].pval : 16'd0;
  end

`ifndef SYNTH
  a_no_pop_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !pop_o)
    else $error("transfer taken from queue during clearing pass");

  a_smooth_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b2_v_q |-> (b2_sm_q <= spdl_pkg::ONE_Q16))
    else $error("phase smoothing value above one");

  a_clear_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> ($past(clr_cnt_q) == AW'(BINS - 1)))
    else $error("clearing pass ended early");
`endif

endmodule

`default_nettype wire

### src/spectrum_peak_decay_log_scaler.sv
// spectrum_peak_decay_log_scaler: top level, configuration registers and the
// front end, queue and back end. Uses spdl_pkg, spdl_front, spdl_fifo, spdl_back.
//
// Input channel in_valid_i/in_ready_o/in_data_i carries one spectrum bin per
// transfer; output channel out_valid_o/out_ready_i/out_data_o carries one
// result per bin, in order. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i, by the user only while the block is idle; the
// block does not enforce this. Throughput is one bin per cycle unless the
// output stalls or clearing runs. Bins pass 36 front stages (square-root
// digits and divider bits), the queue, the store read-modify-write and 16
// log2 square steps with scaling. Back-to-back bins of the same index are
// bypassed. After reset a clearing pass writes zeros to every store entry,
// with in_ready_o low. When the receiver stalls, the back end holds, the
// queue fills, and then the front end stops taking input.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_peak_decay_log_scaler #(
  parameter int unsigned BINS = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spdl_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spdl_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [15:0]    cfg_wdata_i
);

  spdl_pkg::cfg_t cfg_q;
  logic           busy;
  logic           full, empty, push, pop;
  spdl_pkg::fq_t  push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= spdl_pkg::RST_MODE;
      cfg_q.decay_pole <= spdl_pkg::RST_DECAY;
      cfg_q.phase_pole <= spdl_pkg::RST_PHASE;
      cfg_q.log_floor  <= spdl_pkg::RST_FLOOR;
      cfg_q.log_scale  <= spdl_pkg::RST_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spdl_pkg::REG_MODE:  cfg_q.mode       <= cfg_wdata_i[1:0];
        spdl_pkg::REG_DECAY: cfg_q.decay_pole <= cfg_wdata_i;
        spdl_pkg::REG_PHASE: cfg_q.phase_pole <= cfg_wdata_i;
        spdl_pkg::REG_FLOOR: cfg_q.log_floor  <= cfg_wdata_i;
        spdl_pkg::REG_SCALE: cfg_q.log_scale  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  spdl_front #(
    .BINS (BINS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .busy_i      (busy),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  spdl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  spdl_back #(
    .BINS (BINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### tb/spectrum_peak_decay_log_scaler_test.sv
// spectrum_peak_decay_log_scaler_test: self-checking bench, directed table then randomized
// register phases, results compared in order against a bit-exact predictor.
// Depends on spdl_pkg and spectrum_peak_decay_log_scaler.
`timescale 1ns / 1ps

module spectrum_peak_decay_log_scaler_test;
  import spdl_pkg::*;

  localparam int NBINS = 1024;
  localparam int SETTLE = 70;
  localparam int WD_LIMIT = 6000;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic [1:0] mode;
    in_t        d;
    logic       has_exp;
    out_t       exp_out;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  spectrum_peak_decay_log_scaler dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  int unsigned lpeak[NBINS];
  int unsigned rpeak[NBINS];
  int unsigned psmooth[NBINS];
  cfg_t cfg;

  out_t level_q[$];
  int errors = 0;
  int n_in = 0, n_out = 0, n_sat = 0;
  bit calm = 0;
  int hold_reqs = 0, hold_seen = 0, stall_left = 0;
  int idle_cnt = 0;

  function automatic int unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 34;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return int'(r);
  endfunction

  function automatic int unsigned magnitude(int re, int im);
    return isqrt(longint'(re) * re + longint'(im) * im);
  endfunction

  function automatic longint log2_q16(int unsigned p);
    int e;
    longint unsigned m;
    longint frac;
    e = 0;
    frac = 0;
    while (e < 31 && (p >> (e + 1)) != 0) e++;
    m = longint'(p) << (30 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac |= 1;
        m >>= 1;
      end
    end
    return longint'(e - 15) * 65536 + frac;
  endfunction

  function automatic int unsigned level_of(int unsigned p);
    longint d;
    longint unsigned v;
    if (p == 0) return 0;
    d = log2_q16(p) - longint'($signed(cfg.log_floor)) * 256;
    if (d <= 0) return 0;
    v = (longint'(d) * cfg.log_scale) >> 16;
    return (v > 65535) ? 65535 : int'(v);
  endfunction

  function automatic int unsigned peak_hold(int unsigned pk, int unsigned mag);
    pk = int'((longint'(pk) * cfg.decay_pole) >> 16);
    if (mag > pk) pk = mag;
    return pk & 32'h1FFFF;
  endfunction

  function automatic out_t predict_levels(in_t d);
    out_t o;
    int unsigned b, lm, rm, sum, x;
    longint unsigned ratio;
    int lr, li, rr, ri;
    b = d.bin_index % NBINS;
    lr = d.left_real;
    li = d.left_imag;
    rr = d.right_real;
    ri = d.right_imag;
    lm = magnitude(lr, li);
    rm = magnitude(rr, ri);
    o = '0;
    o.out_bin = d.bin_index;
    if (cfg.mode == MODE_SEP) begin
      lpeak[b] = peak_hold(lpeak[b], lm);
      rpeak[b] = peak_hold(rpeak[b], rm);
      o.left_level = 16'(level_of(lpeak[b]));
      o.right_level = 16'(level_of(rpeak[b]));
    end else if (cfg.mode == MODE_PHASE) begin
      sum = lm + rm;
      if (sum == 0) begin
        x = 65536;
      end else begin
        ratio = (longint'(magnitude(lr + rr, li + ri)) << 16) / sum;
        if (ratio > 65536) ratio = 65536;
        x = 65536 - int'(ratio);
      end
      lpeak[b] = peak_hold(lpeak[b], sum >> 1);
      psmooth[b] = int'((longint'(psmooth[b]) * cfg.phase_pole +
                         longint'(x) * (65536 - cfg.phase_pole)) >> 16) & 32'h1FFFF;
      o.left_level = 16'(level_of(lpeak[b]));
      o.phase_level = (psmooth[b] > 65535) ? 16'hFFFF : 16'(psmooth[b]);
    end else begin
      lpeak[b] = peak_hold(lpeak[b], lm);
      o.left_level = 16'(level_of(lpeak[b]));
    end
    return o;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'($signed($urandom_range(128)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_t rand_bin_item();
    in_t d;
    d.bin_index = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(7));
    d.left_real = rand_sample();
    d.left_imag = rand_sample();
    case ($urandom_range(3))
      0: begin
        d.right_real = d.left_real;
        d.right_imag = d.left_imag;
      end
      1: begin
        d.right_real = -d.left_real;
        d.right_imag = -d.left_imag;
      end
      default: begin
        d.right_real = rand_sample();
        d.right_imag = rand_sample();
      end
    endcase
    return d;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_MODE: cfg.mode = val[1:0];
      REG_DECAY: cfg.decay_pole = val;
      REG_PHASE: cfg.phase_pole = val;
      REG_FLOOR: cfg.log_floor = val;
      default: cfg.log_scale = val;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (level_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // one input transfer; expectation typed in or predicted
  task automatic send_bin(in_t d, bit has_exp, out_t exp_out);
    bit rdy;
    out_t p;
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    p = predict_levels(d);
    level_q.push_back(has_exp ? exp_out : p);
    n_in++;
    if (!calm && $urandom_range(99) < 23) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 23);
    end
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_seen < hold_reqs) begin
      hold_seen <= hold_seen + 1;
      stall_left <= 300;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 23);
    end
  end

  // result check and watchdog
  always @(negedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      idle_cnt <= 0;
      n_out++;
      if (out_data_o.left_level == 16'hFFFF) n_sat++;
      if (level_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: %p", out_data_o);
      end else begin
        e = level_q.pop_front();
        if (e !== out_data_o) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", e, out_data_o);
        end
      end
    end else if (in_valid_i && in_ready_o) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WD_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
      $display("** spectrum_peak_decay_log_scaler: FAILED **");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  row_t tab[13];
  cfg_t phases[9];

  initial begin
    out_t z;
    z = '0;
    tab[0] = '{MODE_MONO, '{10'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '0};
    tab[1] = '{MODE_MONO, '{10'd1023, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0}, 1'b0, z};
    tab[2] = '{MODE_MONO, '{10'd1023, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF},
               1'b0, z};
    tab[3] = '{MODE_MONO, '{10'd5, 16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, z};
    tab[4] = '{MODE_SEP, '{10'd2, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, z};
    tab[5] = '{MODE_SEP, '{10'd3, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000}, 1'b0, z};
    tab[6] = '{MODE_PHASE, '{10'd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
               '{10'd4, 16'd0, 16'd0, 16'd336}};
    tab[7] = '{MODE_PHASE, '{10'd6, 16'sd100, 16'sd0, -16'sd100, 16'sd0}, 1'b0, z};
    tab[8] = '{MODE_PHASE, '{10'd7, 16'sd300, -16'sd50, 16'sd300, -16'sd50}, 1'b0, z};
    tab[9] = '{MODE_PHASE, '{10'd8, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, z};
    tab[10] = '{MODE_PHASE, '{10'd8, 16'sh8000, 16'sd7, 16'sd3, 16'sh8000}, 1'b0, z};
    tab[11] = '{2'd3, '{10'd9, 16'sd1234, -16'sd999, 16'sh7FFF, 16'sd1}, 1'b0, z};
    tab[12] = '{MODE_MONO, '{10'd9, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, z};

    phases[0] = '{MODE_SEP, 16'd0, 16'd0, 16'h8000, 16'hFFFF};
    phases[1] = '{MODE_PHASE, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF};
    phases[2] = '{MODE_PHASE, 16'd0, 16'd0, RST_FLOOR, RST_SCALE};
    phases[3] = '{MODE_MONO, 16'hFFFF, RST_PHASE, 16'h8000, 16'd0};
    for (int i = 4; i < 8; i++) begin
      phases[i] = '{2'(i), 16'($urandom), 16'($urandom), 16'(-$urandom_range(12000)),
                    16'($urandom)};
    end
    phases[8] = '{MODE_SEP, RST_DECAY, RST_PHASE, RST_FLOOR, RST_SCALE};

    for (int i = 0; i < NBINS; i++) begin
      lpeak[i] = 0;
      rpeak[i] = 0;
      psmooth[i] = 0;
    end
    cfg = '{RST_MODE, RST_DECAY, RST_PHASE, RST_FLOOR, RST_SCALE};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (tab[i]) begin
      if (tab[i].mode != cfg.mode) begin
        drain();
        write_reg(REG_MODE, {14'd0, tab[i].mode});
        end_writes();
      end
      send_bin(tab[i].d, tab[i].has_exp, tab[i].exp_out);
    end

    foreach (phases[p]) begin
      drain();
      write_reg(REG_MODE, {14'd0, phases[p].mode});
      write_reg(REG_DECAY, phases[p].decay_pole);
      write_reg(REG_PHASE, phases[p].phase_pole);
      write_reg(REG_FLOOR, phases[p].log_floor);
      write_reg(REG_SCALE, phases[p].log_scale);
      end_writes();
      calm = (p == 6);
      if (p == 4) hold_reqs++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_bin(rand_bin_item(), 1'b0, z);
      end
    end
    drain();

    $display("%0d bins sent, %0d results checked (%0d saturated) over 4 modes", n_in,
             n_out, n_sat);
    $display("register phases: %0d, long output hold-off and full drains included",
             $size(phases));
    if (errors == 0 && level_q.size() == 0) begin
      $display("** spectrum_peak_decay_log_scaler: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, level_q.size());
      $display("** spectrum_peak_decay_log_scaler: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
src/spdl_pkg.sv
src/spdl_fifo.sv
src/spdl_front.sv
src/spdl_back.sv
src/spectrum_peak_decay_log_scaler.sv
tb/spectrum_peak_decay_log_scaler_test.sv
